### rtl/qdft_pkg.sv
// ----------------------------------------------------------------------------
// qdft_pkg
// Shared types and constants of the quoted delimited field tokenizer.
// ----------------------------------------------------------------------------
package qdft_pkg;

  localparam int unsigned CharW    = 16;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned MaxSlots = 3;

  localparam logic [CharW-1:0] QuoteChar  = 16'h0022;
  localparam logic [CharW-1:0] DelimReset = 16'd44;

  // register index (paddr above the byte offset)
  localparam logic [AddrW-3:0] RegDelim = 1'b0;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_RECORD_OK = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE           = 2'd0,
    ERR_AFTER_CLOSE    = 2'd1,
    ERR_QUOTE_UNQUOTED = 2'd2,
    ERR_UNTERMINATED   = 2'd3
  } err_e;

  typedef struct packed {
    kind_e kind;
    err_e  err;
  } slot_t;

  // all results caused by one request
  typedef struct packed {
    logic [1:0]                count;
    slot_t [MaxSlots-1:0]      slots;
    logic [CharW-1:0]          char_value;
  } entry_t;

endpackage

### rtl/qdft_front.sv
// ----------------------------------------------------------------------------
// qdft_front
// Accepts characters, tracks the quoting state and classifies each request
// into a bundle of up to three results for the queue.
// ----------------------------------------------------------------------------
module qdft_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [15:0]             code_unit_i,
  input  logic                    record_end_i,
  input  logic [15:0]             delim_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output qdft_pkg::entry_t        entry_o
);
  import qdft_pkg::*;

  typedef enum logic [4:0] {
    MODE_UNQUOTED = 5'b00001,
    MODE_QUOTED   = 5'b00010,
    MODE_PENDQ    = 5'b00100,
    MODE_CLOSED   = 5'b01000,
    MODE_DISCARD  = 5'b10000
  } mode_e;

  mode_e mode_q, mode_d;
  logic  nonempty_q, nonempty_d;
  logic  accept;

  entry_t entry;

  always_comb begin
    mode_e      m;
    logic       ne;
    logic       handled;
    err_e       err;
    logic [1:0] n;
    logic       is_quote;
    logic       is_delim;

    m        = mode_q;
    ne       = nonempty_q;
    handled  = 1'b0;
    err      = ERR_NONE;
    n        = 2'd0;
    is_quote = (code_unit_i == QuoteChar);
    is_delim = (code_unit_i == delim_i);
    entry.slots      = '0;
    entry.char_value = code_unit_i;

    if (mode_q == MODE_DISCARD) begin
      if (record_end_i) begin
        m  = MODE_UNQUOTED;
        ne = 1'b0;
      end
    end else begin
      if (mode_q == MODE_PENDQ) begin
        if (is_quote) begin
          entry.slots[n] = slot_t'{KIND_CHAR, ERR_NONE};
          n       = n + 2'd1;
          m       = MODE_QUOTED;
          handled = 1'b1;
        end else begin
          m = MODE_CLOSED;
        end
      end

      if (!handled) begin
        case (m)
          MODE_QUOTED: begin
            if (is_quote) begin
              m = record_end_i ? MODE_CLOSED : MODE_PENDQ;
            end else begin
              entry.slots[n] = slot_t'{KIND_CHAR, ERR_NONE};
              n = n + 2'd1;
            end
          end
          MODE_CLOSED: begin
            if (is_delim) begin
              entry.slots[n] = slot_t'{KIND_FIELD_END, ERR_NONE};
              n  = n + 2'd1;
              m  = MODE_UNQUOTED;
              ne = 1'b0;
            end else begin
              err = ERR_AFTER_CLOSE;
            end
          end
          default: begin
            m = MODE_UNQUOTED;
            if (is_delim) begin
              entry.slots[n] = slot_t'{KIND_FIELD_END, ERR_NONE};
              n  = n + 2'd1;
              ne = 1'b0;
            end else if (is_quote) begin
              if (ne) begin
                err = ERR_QUOTE_UNQUOTED;
              end else begin
                m = MODE_QUOTED;
              end
            end else begin
              entry.slots[n] = slot_t'{KIND_CHAR, ERR_NONE};
              n  = n + 2'd1;
              ne = 1'b1;
            end
          end
        endcase
      end

      if (err != ERR_NONE) begin
        entry.slots[n] = slot_t'{KIND_ERROR, err};
        n  = n + 2'd1;
        m  = record_end_i ? MODE_UNQUOTED : MODE_DISCARD;
        ne = 1'b0;
      end else if (record_end_i) begin
        if (m == MODE_QUOTED || m == MODE_PENDQ) begin
          entry.slots[n] = slot_t'{KIND_ERROR, ERR_UNTERMINATED};
          n = n + 2'd1;
        end else begin
          entry.slots[n] = slot_t'{KIND_FIELD_END, ERR_NONE};
          n = n + 2'd1;
          entry.slots[n] = slot_t'{KIND_RECORD_OK, ERR_NONE};
          n = n + 2'd1;
        end
        m  = MODE_UNQUOTED;
        ne = 1'b0;
      end
    end

    // a quote escaped by a doubled quote is the only char not taken verbatim
    if (mode_q == MODE_PENDQ) begin
      entry.char_value = QuoteChar;
    end

    entry.count = n;
    mode_d      = m;
    nonempty_d  = ne;
  end

  assign accept     = in_valid_i & ~q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept & (entry.count != 2'd0);
  assign entry_o    = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_UNQUOTED;
      nonempty_q <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      nonempty_q <= nonempty_d;
    end
  end

endmodule

### rtl/qdft_queue.sv
// ----------------------------------------------------------------------------
// qdft_queue
// Small FIFO of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module qdft_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  qdft_pkg::entry_t              entry_i,
  input  logic                          pop_i,
  output logic                          full_o,
  output logic                          valid_o,
  output qdft_pkg::entry_t              entry_o,
  output logic [$clog2(Depth+1)-1:0]    level_o
);
  import qdft_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign level_o = count_q;

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/qdft_back.sv
// ----------------------------------------------------------------------------
// qdft_back
// Walks the head bundle's results one per cycle, unless stalled, into the
// output register and pops the bundle after its last result.
// ----------------------------------------------------------------------------
module qdft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  qdft_pkg::entry_t    q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [15:0]         char_value_o,
  output logic [1:0]          error_code_o,
  output logic                last_of_run_o
);
  import qdft_pkg::*;

  logic [1:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q;
  err_e             err_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  logic  load;
  logic  last;
  slot_t slot;

  assign load = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign slot = q_entry_i.slots[idx_q];
  assign last = (idx_q == q_entry_i.count - 2'd1);

  assign q_pop_o = load & last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= slot.kind;
      err_q  <= slot.err;
      char_q <= (slot.kind == KIND_CHAR) ? q_entry_i.char_value : '0;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign char_value_o  = char_q;
  assign error_code_o  = err_q;
  assign last_of_run_o = last_q;

endmodule

### rtl/quoted_delimited_field_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_delimited_field_tokenizer
// Splits a stream of 16-bit characters into double-quoted or plain fields.
// ----------------------------------------------------------------------------
// Input channel: one character per request (code_unit_i, record_end_i marks
// the last character of a record), valid/stall handshake.
// Output channel: field characters, end-of-field, end-of-record and error
// results; last_of_run_o flags the final result of one input request.
// Config: APB-style port, field_delimiter at byte address 0 (reset ',').
// Flow: the first result of a request is written into the bundle queue and
// then loaded into the output register. Throughput: one request per cycle
// while each gives at most one result and the output is not stalled; a
// request giving two or three results shows them in turn through the single
// output register of the back end; one giving no result pushes nothing.
// The front end and back end are joined by a QueueDepth-entry bundle queue;
// in_stall_o rises only when that queue is full, so a stalled receiver backs
// up into the queue and then into the input.
// Reset clears the parse state, the queue and the output valid; the
// delimiter returns to ','. A write to the delimiter applies to the next
// accepted request.
// ----------------------------------------------------------------------------
module quoted_delimited_field_tokenizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [15:0]                  code_unit_i,
  input  logic                         record_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [15:0]                  char_value_o,
  output logic [1:0]                   error_code_o,
  output logic                         last_of_run_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qdft_pkg::AddrW-1:0]   paddr,
  input  logic [qdft_pkg::DataW-1:0]   pwdata,
  output logic [qdft_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import qdft_pkg::*;

  logic [CharW-1:0] delim_q;
  logic             reg_hit;

  logic    push;
  entry_t  push_entry;
  logic    q_full;
  logic    q_valid;
  entry_t  q_entry;
  logic    q_pop;
  logic [$clog2(QueueDepth+1)-1:0] q_level;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1:2] == RegDelim);
  assign prdata  = reg_hit ? {{(DataW-CharW){1'b0}}, delim_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      delim_q <= pwdata[CharW-1:0];
    end
  end

  qdft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_unit_i  (code_unit_i),
    .record_end_i (record_end_i),
    .delim_i      (delim_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  qdft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .level_o (q_level)
  );

  qdft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .char_value_o  (char_value_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_CHAR |-> char_value_o == '0)
    else $error("char_value set on a marker result");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((error_code_o != ERR_NONE) == (kind_o == KIND_ERROR)))
    else $error("error_code and kind disagree");

  a_rec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_RECORD_OK || kind_o == KIND_ERROR)
      |-> last_of_run_o)
    else $error("record end or error is not the last result");

  a_q_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= ($clog2(QueueDepth+1))'(QueueDepth) && (in_stall_o == q_full))
    else $error("queue level out of range");

endmodule
